### design/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// Types, codes and character tables shared by the request-line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

   localparam int MethodCount = 8;

   // parse stage codes
   localparam logic [2:0] STAGE_METHOD = 3'd0;
   localparam logic [2:0] STAGE_URI    = 3'd1;
   localparam logic [2:0] STAGE_CR     = 3'd2;
   localparam logic [2:0] STAGE_LF     = 3'd3;
   localparam logic [2:0] STAGE_DONE   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_METHOD = 2'd1;
   localparam logic [1:0] STATUS_EARLY_EOL  = 2'd2;
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd3;

   localparam logic [3:0] VERSION_LEN = 4'd9;

   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   typedef struct packed {
      logic [2:0] stage;
      logic [2:0] method_position;
      logic [7:0] method_candidates;
      logic [3:0] version_matched;
      logic [1:0] verdict;
      logic [2:0] found_method;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      stage:             STAGE_METHOD,
      method_position:   3'd0,
      method_candidates: 8'hff,
      version_matched:   4'd0,
      verdict:           STATUS_INCOMPLETE,
      found_method:      3'd0
   };

   // length of each method including its trailing space
   function automatic logic [3:0] method_len(input logic [2:0] idx);
      logic [3:0] len;
      case (idx)
         3'd0: len = 4'd8;
         3'd1: len = 4'd4;
         3'd2: len = 4'd5;
         3'd3: len = 4'd5;
         3'd4: len = 4'd4;
         3'd5: len = 4'd7;
         3'd6: len = 4'd6;
         3'd7: len = 4'd8;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] method_char(input logic [2:0] idx,
                                              input logic [2:0] pos);
      logic [63:0] text;
      case (idx)
         3'd0: text = "OPTIONS ";
         3'd1: text = "GET     ";
         3'd2: text = "HEAD    ";
         3'd3: text = "POST    ";
         3'd4: text = "PUT     ";
         3'd5: text = "DELETE  ";
         3'd6: text = "TRACE   ";
         3'd7: text = "CONNECT ";
         default: text = '0;
      endcase
      return text[(7 - pos) * 8 +: 8];
   endfunction

   function automatic logic [7:0] version_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0: c = " ";
         4'd1: c = "H";
         4'd2: c = "T";
         4'd3: c = "T";
         4'd4: c = "P";
         4'd5: c = "/";
         4'd6: c = "1";
         4'd7: c = ".";
         4'd8: c = "1";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### design/hrlc_step.sv
// ----------------------------------------------------------------------------
// hrlc_step
// Next-state and result logic for one packet byte.
// ----------------------------------------------------------------------------
module hrlc_step
   import hrlc_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output parse_state_type nxt_state,
   output logic            result_valid,
   output logic [1:0]      status,
   output logic [2:0]      method_index
);

   parse_state_type upd;
   logic [7:0]      live;
   logic            done;
   logic [2:0]      found;

   always_comb begin
      upd   = cur_state;
      live  = '0;
      done  = 1'b0;
      found = cur_state.found_method;
      case (cur_state.stage)
         STAGE_METHOD: begin
            for (int i = 0; i < MethodCount; i++) begin
               if (cur_state.method_candidates[i] &&
                   ({1'b0, cur_state.method_position} < method_len(3'(i))) &&
                   (method_char(3'(i), cur_state.method_position) == data_byte)) begin
                  if (({1'b0, cur_state.method_position} + 4'd1) ==
                      method_len(3'(i))) begin
                     found = 3'(i);
                     done  = 1'b1;
                  end else begin
                     live[i] = 1'b1;
                  end
               end
            end
            if (done) begin
               upd.stage           = STAGE_URI;
               upd.version_matched = 4'd0;
               upd.found_method    = found;
            end else if (live == '0) begin
               upd.verdict = STATUS_BAD_METHOD;
               upd.stage   = STAGE_DONE;
            end else begin
               upd.method_candidates = live;
               upd.method_position   = cur_state.method_position + 3'd1;
            end
         end
         STAGE_URI: begin
            if ((cur_state.version_matched != 4'd0) &&
                (cur_state.version_matched < VERSION_LEN) &&
                (data_byte == version_char(cur_state.version_matched))) begin
               upd.version_matched = cur_state.version_matched + 4'd1;
               if ((cur_state.version_matched + 4'd1) == VERSION_LEN) begin
                  upd.stage = STAGE_CR;
               end
            end else if (data_byte == CHAR_SP) begin
               upd.version_matched = 4'd1;
            end else if ((data_byte == CHAR_CR) || (data_byte == CHAR_LF)) begin
               upd.verdict = STATUS_EARLY_EOL;
               upd.stage   = STAGE_DONE;
            end else begin
               upd.version_matched = 4'd0;
            end
         end
         STAGE_CR: begin
            if (data_byte == CHAR_CR) begin
               upd.stage = STAGE_LF;
            end else begin
               upd.verdict = STATUS_INCOMPLETE;
               upd.stage   = STAGE_DONE;
            end
         end
         STAGE_LF: begin
            upd.verdict = (data_byte == CHAR_LF) ? STATUS_OK : STATUS_INCOMPLETE;
            upd.stage   = STAGE_DONE;
         end
         default: begin
            upd = cur_state;
         end
      endcase
   end

   always_comb begin
      case (upd.stage)
         STAGE_DONE:   status = upd.verdict;
         STAGE_METHOD: status = STATUS_BAD_METHOD;
         default:      status = STATUS_INCOMPLETE;
      endcase
      method_index = (status == STATUS_BAD_METHOD) ? 3'd0 : upd.found_method;
      result_valid = last_byte;
      nxt_state    = last_byte ? PARSE_STATE_RESET : upd;
   end

endmodule

### design/http_request_line_checker.sv
// ----------------------------------------------------------------------------
// http_request_line_checker
// Checks that a packet opens with METHOD SP URI " HTTP/1.1" CR LF and
// reports a status and method index on the last byte of each packet.
// ----------------------------------------------------------------------------
//   channel  direction  ports                                  handshake
//   req      in         req_data_byte, req_last_byte           req_valid / req_stall
//   rsp      out        rsp_status, rsp_method_index           rsp_valid / rsp_stall
//
// one byte per cycle while rsp_stall does not hold the output register; the parse state updates once per byte
// a result passes from the input register through the parse step into the output register
// reset returns the parse state to the method stage and empties both registers
// rsp_stall holds the output item and backs up into req_stall only when the
// input register cannot move forward
module http_request_line_checker
   import hrlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_method_index
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_data_ff;
   logic            in_last_ff;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   logic [1:0]      out_status_ff;
   logic [2:0]      out_index_ff;

   logic            advance;
   logic            req_take;
   logic            step_valid;
   logic [1:0]      step_status;
   logic [2:0]      step_index;

   hrlc_step u_step (
      .cur_state    (state_ff),
      .data_byte    (in_data_ff),
      .last_byte    (in_last_ff),
      .nxt_state    (state_in),
      .result_valid (step_valid),
      .status       (step_status),
      .method_index (step_index)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && step_valid) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && step_valid) begin
         out_status_ff <= step_status;
         out_index_ff  <= step_index;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_method_index = out_index_ff;

endmodule
